// File: sv/leua_pkg.sv
// Shared types and constants of the encoder unwrap and electrical angle block.
`timescale 1ns / 1ps
`default_nettype none
package leua_pkg;

  localparam int FRAME_W   = 18;
  localparam int FLAG_W    = 6;
  localparam int POS_W     = 12;  // one period is 2**POS_W counts
  localparam int WRAP_W    = 16;
  localparam int UNW_W     = WRAP_W + POS_W;
  localparam int CFG_W     = 16;
  localparam int ANGLE_W   = 16;

  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 64;
  localparam int APB_ADDR_W  = 3;
  localparam int APB_DATA_W  = 32;

  localparam logic [POS_W:0] HALF_PERIOD = (POS_W + 1)'(2 ** (POS_W - 1));

  localparam logic [CFG_W-1:0] CPPP_RST   = 16'd4096;
  localparam logic [CFG_W-1:0] OFFSET_RST = 16'd1658;

  // Divider steps: one dividend bit per cycle
  localparam int DIV_CNT_W = $clog2(UNW_W);

  // Scale by 32/25: x = rem << 5, then floor(x / 25) by reciprocal multiply
  localparam int SCALE_SHIFT = 5;
  localparam int X_W         = CFG_W + SCALE_SHIFT;
  localparam int RECIP_SHIFT = 26;
  localparam int RECIP_W     = 22;
  localparam logic [RECIP_W-1:0] RECIP_MULT = RECIP_W'((2 ** RECIP_SHIFT + 24) / 25);
  localparam int PROD_W      = X_W + RECIP_W;
  localparam int QUOT_W      = PROD_W - RECIP_SHIFT;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_START,
    ST_DIV,
    ST_SCALE
  } state_e;

  typedef enum logic {
    REG_CPPP   = 1'b0,
    REG_OFFSET = 1'b1
  } reg_e;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage
`default_nettype wire

// File: sv/leua_cfg.sv
// Configuration registers behind the APB port.
`timescale 1ns / 1ps
`default_nettype none
module leua_cfg (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [leua_pkg::APB_ADDR_W-1:0]   paddr,
  input  wire logic [leua_pkg::APB_DATA_W-1:0]   pwdata,
  output logic      [leua_pkg::APB_DATA_W-1:0]   prdata,
  output logic                                   pready,
  output logic      [leua_pkg::CFG_W-1:0]        cppp_o,
  output logic      [leua_pkg::CFG_W-1:0]        offset_o
);

  logic [leua_pkg::CFG_W-1:0] cppp_q, cppp_d;
  logic [leua_pkg::CFG_W-1:0] offset_q, offset_d;
  leua_pkg::reg_e             addr_sel;
  logic                       wr_en;

  assign pready   = 1'b1;
  assign addr_sel = leua_pkg::reg_e'(paddr[2]);
  assign wr_en    = psel && penable && pwrite && pready;

  always_comb begin
    cppp_d   = cppp_q;
    offset_d = offset_q;
    prdata   = '0;
    unique case (addr_sel)
      leua_pkg::REG_CPPP: begin
        prdata = {{(leua_pkg::APB_DATA_W - leua_pkg::CFG_W){1'b0}}, cppp_q};
        if (wr_en) cppp_d = pwdata[leua_pkg::CFG_W-1:0];
      end
      leua_pkg::REG_OFFSET: begin
        prdata = {{(leua_pkg::APB_DATA_W - leua_pkg::CFG_W){1'b0}}, offset_q};
        if (wr_en) offset_d = pwdata[leua_pkg::CFG_W-1:0];
      end
      default: prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cppp_q   <= leua_pkg::CPPP_RST;
      offset_q <= leua_pkg::OFFSET_RST;
    end else begin
      cppp_q   <= cppp_d;
      offset_q <= offset_d;
    end
  end

  assign cppp_o   = cppp_q;
  assign offset_o = offset_q;

endmodule
`default_nettype wire

// File: sv/leua_unwrap.sv
// Period tracking: last position and wrap counter, unwrapped position.
`timescale 1ns / 1ps
`default_nettype none
module leua_unwrap (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          en_i,
  input  wire logic [leua_pkg::POS_W-1:0]    pos_i,
  output logic      [leua_pkg::UNW_W-1:0]    unw_o
);

  logic [leua_pkg::POS_W-1:0]  last_q, last_d;
  logic [leua_pkg::WRAP_W-1:0] wrap_q, wrap_d;
  logic [leua_pkg::POS_W:0]    diff;
  logic                        step_up, step_dn;

  always_comb begin
    diff    = {1'b0, last_q} - {1'b0, pos_i};
    step_up = $signed(diff) > $signed(leua_pkg::HALF_PERIOD);
    step_dn = $signed(diff) < -$signed(leua_pkg::HALF_PERIOD);
    wrap_d  = wrap_q;
    last_d  = last_q;
    if (en_i) begin
      last_d = pos_i;
      if (step_up) wrap_d = wrap_q + 1'b1;
      else if (step_dn) wrap_d = wrap_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q <= '0;
      wrap_q <= '0;
    end else begin
      last_q <= last_d;
      wrap_q <= wrap_d;
    end
  end

  // One period is a power of two: counter and position concatenate
  assign unw_o = {wrap_d, pos_i};

endmodule
`default_nettype wire

// File: sv/leua_div.sv
// Restoring divider, one dividend bit per cycle; yields the remainder.
`timescale 1ns / 1ps
`default_nettype none
module leua_div (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  input  wire logic [leua_pkg::UNW_W-1:0]    dividend_i,
  input  wire logic [leua_pkg::CFG_W-1:0]    divisor_i,
  output logic      [leua_pkg::CFG_W-1:0]    rem_o,
  output leua_pkg::div_stat_t                stat_o
);

  logic [leua_pkg::UNW_W-1:0]     dvd_q, dvd_d;
  logic [leua_pkg::CFG_W-1:0]     dsr_q, dsr_d;
  logic [leua_pkg::CFG_W-1:0]     rem_q, rem_d;
  logic [leua_pkg::DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic                           busy_q, busy_d;
  logic                           done_q, done_d;
  logic [leua_pkg::CFG_W:0]       trial;
  logic [leua_pkg::CFG_W+1:0]     sub;

  always_comb begin
    trial  = {rem_q, dvd_q[leua_pkg::UNW_W-1]};
    sub    = {1'b0, trial} - {2'b00, dsr_q};
    dvd_d  = dvd_q;
    dsr_d  = dsr_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      dvd_d  = dividend_i;
      dsr_d  = divisor_i;
      rem_d  = '0;
      cnt_d  = leua_pkg::DIV_CNT_W'(leua_pkg::UNW_W - 1);
      busy_d = 1'b1;
    end else if (busy_q) begin
      // keep the difference when the divisor fits, else restore
      rem_d = sub[leua_pkg::CFG_W+1] ? trial[leua_pkg::CFG_W-1:0] : sub[leua_pkg::CFG_W-1:0];
      dvd_d = {dvd_q[leua_pkg::UNW_W-2:0], 1'b0};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    dsr_q <= dsr_d;
    rem_q <= rem_d;
  end

  // zero divisor gives a zero remainder
  assign rem_o       = (dsr_q == '0) ? '0 : rem_q;
  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

endmodule
`default_nettype wire

// File: sv/linear_encoder_unwrap_angle_core.sv
// Top level: frame decode, unwrap, remainder, 32/25 scaling and output register.
// An accepted item goes through the start state, the divide state and the scale state into the output register.
// One item is at work at a time, and the 28-step divider sets the pace; a new item is taken only back in idle.
// Input is not ready while an item is at work; a waiting result stalls only the last step.
// Reset: asynchronous, active low; clears the wrap counter, last position, sequencer and
// output valid, and loads the register reset values.
`timescale 1ns / 1ps
`default_nettype none
module linear_encoder_unwrap_angle_core (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  // tdata: raw_frame[17:0], zero pad [23:18]
  input  wire logic                                s_axis_tvalid_i,
  output logic                                     s_axis_tready_o,
  input  wire logic [leua_pkg::IN_TDATA_W-1:0]     s_axis_tdata_i,
  // tdata: electrical_angle[15:0], unwrapped_position[43:16], raw_position[55:44],
  // parity_bit[56], magnet_decrease[57], magnet_increase[58], linearity_alarm[59],
  // cordic_overflow[60], offset_done[61], zero pad [63:62]
  output logic                                     m_axis_tvalid_o,
  input  wire logic                                m_axis_tready_i,
  output logic      [leua_pkg::OUT_TDATA_W-1:0]    m_axis_tdata_o,
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [leua_pkg::APB_ADDR_W-1:0]     paddr,
  input  wire logic [leua_pkg::APB_DATA_W-1:0]     pwdata,
  output logic      [leua_pkg::APB_DATA_W-1:0]     prdata,
  output logic                                     pready
);

  leua_pkg::state_e                 state_q, state_d;
  leua_pkg::div_stat_t              div_st;
  logic [leua_pkg::CFG_W-1:0]       cppp, offset;
  logic [leua_pkg::FRAME_W-1:0]     frame;
  logic [leua_pkg::POS_W-1:0]       pos_in;
  logic [leua_pkg::UNW_W-1:0]       unw_new;
  logic [leua_pkg::FLAG_W-1:0]      flags_q, flags_d;
  logic [leua_pkg::POS_W-1:0]       pos_q, pos_d;
  logic [leua_pkg::UNW_W-1:0]       unw_q, unw_d;
  logic [leua_pkg::UNW_W-1:0]       mag;
  logic                             neg;
  logic [leua_pkg::CFG_W-1:0]       rem;
  logic [leua_pkg::X_W-1:0]         x_val;
  logic [leua_pkg::PROD_W-1:0]      prod_q, prod_d;
  logic [leua_pkg::QUOT_W-1:0]      quot;
  logic [leua_pkg::ANGLE_W-1:0]     q_lo, angle;
  logic [leua_pkg::OUT_TDATA_W-1:0] out_q, out_d;
  logic                             out_valid_q, out_valid_d;
  logic                             in_acc, div_start, out_free, out_load;

  assign frame  = s_axis_tdata_i[leua_pkg::FRAME_W-1:0];
  assign pos_in = frame[leua_pkg::FRAME_W-1:leua_pkg::FLAG_W];
  assign in_acc = s_axis_tvalid_i && s_axis_tready_o;

  leua_cfg u_cfg (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .cppp_o   (cppp),
    .offset_o (offset)
  );

  leua_unwrap u_unwrap (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (in_acc),
    .pos_i  (pos_in),
    .unw_o  (unw_new)
  );

  assign neg = unw_q[leua_pkg::UNW_W-1];
  assign mag = neg ? (~unw_q + 1'b1) : unw_q;

  leua_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (mag),
    .divisor_i  (cppp),
    .rem_o      (rem),
    .stat_o     (div_st)
  );

  assign x_val    = {rem, {leua_pkg::SCALE_SHIFT{1'b0}}};
  assign quot     = prod_q[leua_pkg::PROD_W-1:leua_pkg::RECIP_SHIFT];
  assign q_lo     = quot[leua_pkg::ANGLE_W-1:0];
  // apply the unwrapped position's sign, then the offset, modulo 2**16
  assign angle    = offset + (neg ? (~q_lo + 1'b1) : q_lo);
  assign out_free = !out_valid_q || m_axis_tready_i;

  always_comb begin
    state_d         = state_q;
    s_axis_tready_o = 1'b0;
    div_start       = 1'b0;
    out_load        = 1'b0;
    flags_d         = flags_q;
    pos_d           = pos_q;
    unw_d           = unw_q;
    prod_d          = prod_q;
    unique case (state_q)
      leua_pkg::ST_IDLE: begin
        s_axis_tready_o = 1'b1;
        if (s_axis_tvalid_i) begin
          flags_d = frame[leua_pkg::FLAG_W-1:0];
          pos_d   = pos_in;
          unw_d   = unw_new;
          state_d = leua_pkg::ST_START;
        end
      end
      leua_pkg::ST_START: begin
        div_start = 1'b1;
        state_d   = leua_pkg::ST_DIV;
      end
      leua_pkg::ST_DIV: begin
        if (div_st.done) begin
          prod_d  = leua_pkg::PROD_W'(x_val) * leua_pkg::PROD_W'(leua_pkg::RECIP_MULT);
          state_d = leua_pkg::ST_SCALE;
        end
      end
      leua_pkg::ST_SCALE: begin
        // hold until the output register frees up
        if (out_free) begin
          out_load = 1'b1;
          state_d  = leua_pkg::ST_IDLE;
        end
      end
      default: state_d = leua_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    out_d       = out_q;
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_d       = {2'b00, flags_q, pos_q, unw_q, angle};
      out_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= leua_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    flags_q <= flags_d;
    pos_q   <= pos_d;
    unw_q   <= unw_d;
    prod_q  <= prod_d;
    out_q   <= out_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_q;

`ifndef SYNTHESIS
  a_busy_not_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_st.busy |-> !s_axis_tready_o)
    else $error("input ready while divider busy");

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q == leua_pkg::ST_START))
    else $error("accepted item did not start the divider");

  a_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_st.done |-> (state_q == leua_pkg::ST_DIV))
    else $error("divider finished outside the divide state");

  a_start_idle_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |=> div_st.busy)
    else $error("divider did not go busy after start");
`endif

endmodule
`default_nettype wire
